>>> rtl/pbsc_pkg.sv
// Package with the types, codes and reset constants of the power button sleep controller.
package pbsc_pkg;

   localparam int TIME_WIDTH = 48;
   localparam int CFG_WIDTH  = 32;
   localparam int REQ_TDATA_WIDTH = 56;
   localparam int RSP_TDATA_WIDTH = 8;

   // Reset values of the timing registers, in microseconds.
   localparam logic [CFG_WIDTH-1:0] HOLD_DEEP_RESET  = 32'(800 * 1000);
   localparam logic [CFG_WIDTH-1:0] HOLD_OFF_RESET   = 32'(3000 * 1000);
   localparam logic [CFG_WIDTH-1:0] IDLE_LIGHT_RESET = 32'(180 * 1000000);
   localparam logic [CFG_WIDTH-1:0] IDLE_DEEP_RESET  = 32'(900 * 1000000);

   // Register indexes on the configuration channel.
   typedef enum logic [1:0] {
      REG_HOLD_DEEP  = 2'd0,
      REG_HOLD_OFF   = 2'd1,
      REG_IDLE_LIGHT = 2'd2,
      REG_IDLE_DEEP  = 2'd3
   } reg_index_type;

   // Request opcodes.
   typedef enum logic {
      OP_TICK  = 1'b0,
      OP_START = 1'b1
   } opcode_type;

   // Action codes of a result word.
   typedef enum logic [2:0] {
      ACT_NONE        = 3'd0,
      ACT_EXIT_LIGHT  = 3'd1,
      ACT_ENTER_LIGHT = 3'd2,
      ACT_ENTER_DEEP  = 3'd3,
      ACT_POWER_OFF   = 3'd4
   } action_type;

   typedef struct packed {
      opcode_type            opcode;
      logic [TIME_WIDTH-1:0] now_time;
      logic                  key_down;
      logic                  touch_seen;
      logic                  sleep_permitted;
   } req_item_type;

   typedef struct packed {
      action_type action;
      logic       in_light_mode;
   } rsp_item_type;

   typedef struct packed {
      logic [CFG_WIDTH-1:0] hold_deep_time;
      logic [CFG_WIDTH-1:0] hold_off_time;
      logic [CFG_WIDTH-1:0] idle_light_time;
      logic [CFG_WIDTH-1:0] idle_deep_time;
   } cfg_type;

endpackage

>>> rtl/pbsc_csr.sv
// Timing register file of the power button sleep controller.
module pbsc_csr
   import pbsc_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 wr_en,
   input  reg_index_type        wr_index,
   input  logic [CFG_WIDTH-1:0] wr_data,
   output cfg_type              cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // Decode the register index of a write.
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (wr_index)
            REG_HOLD_DEEP:  cfg_in.hold_deep_time  = wr_data;
            REG_HOLD_OFF:   cfg_in.hold_off_time   = wr_data;
            REG_IDLE_LIGHT: cfg_in.idle_light_time = wr_data;
            REG_IDLE_DEEP:  cfg_in.idle_deep_time  = wr_data;
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.hold_deep_time  <= HOLD_DEEP_RESET;
         cfg_ff.hold_off_time   <= HOLD_OFF_RESET;
         cfg_ff.idle_light_time <= IDLE_LIGHT_RESET;
         cfg_ff.idle_deep_time  <= IDLE_DEEP_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

>>> rtl/pbsc_core.sv
// Key and idle state of the controller and the single-pass step logic.
module pbsc_core
   import pbsc_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         step,
   input  req_item_type item,
   input  cfg_type      cfg,
   output rsp_item_type result
);

   logic                  light_mode_ff, light_mode_in;
   logic                  key_prev_ff, key_prev_in;
   logic                  press_consumed_ff, press_consumed_in;
   logic [TIME_WIDTH-1:0] press_start_ff, press_start_in;
   logic [TIME_WIDTH-1:0] last_activity_ff, last_activity_in;

   logic                  press;
   logic                  release_edge;
   logic [TIME_WIDTH-1:0] held;
   logic [TIME_WIDTH-1:0] idle;
   action_type            act;

   // Elapsed times, modulo the timestamp width. Activity in this word resets the idle time.
   assign held = item.now_time - press_start_ff;
   assign idle = (item.touch_seen || item.key_down) ? '0 : item.now_time - last_activity_ff;

   assign press        = item.key_down && !key_prev_ff;
   assign release_edge = !item.key_down && key_prev_ff;

   // Next state and action for one word.
   always_comb begin
      light_mode_in     = light_mode_ff;
      key_prev_in       = item.key_down;
      press_consumed_in = press_consumed_ff;
      press_start_in    = press_start_ff;
      last_activity_in  = last_activity_ff;
      act               = ACT_NONE;

      if (item.opcode == OP_START) begin
         // Resynchronize: a key that is already held is ignored until released.
         last_activity_in  = item.now_time;
         press_consumed_in = item.key_down;
         press_start_in    = item.now_time;
      end else begin
         if (press) begin
            press_start_in    = item.now_time;
            press_consumed_in = 1'b0;
         end
         if (item.touch_seen || item.key_down) begin
            last_activity_in = item.now_time;
         end

         if (light_mode_ff) begin
            if (item.touch_seen || press) begin
               if (press) begin
                  press_consumed_in = 1'b1;
               end
               light_mode_in = 1'b0;
               act           = ACT_EXIT_LIGHT;
            end else if (!item.key_down &&
                         idle >= TIME_WIDTH'(cfg.idle_deep_time)) begin
               act = ACT_ENTER_DEEP;
            end
         end else begin
            // A release classifies the hold length.
            if (release_edge && !press_consumed_ff) begin
               if (held >= TIME_WIDTH'(cfg.hold_off_time)) begin
                  act = ACT_POWER_OFF;
               end else if (item.sleep_permitted) begin
                  act = (held >= TIME_WIDTH'(cfg.hold_deep_time)) ? ACT_ENTER_DEEP
                                                                   : ACT_ENTER_LIGHT;
               end
            end
            if (release_edge) begin
               press_consumed_in = 1'b0;
            end
            if (act == ACT_NONE && item.sleep_permitted && !item.key_down &&
                idle >= TIME_WIDTH'(cfg.idle_light_time)) begin
               act = ACT_ENTER_LIGHT;
            end
            if (act == ACT_ENTER_LIGHT) begin
               light_mode_in = 1'b1;
            end
         end
      end
   end

   // State registers advance once for each word that passes.
   always_ff @(posedge clock) begin
      if (reset) begin
         light_mode_ff     <= 1'b0;
         key_prev_ff       <= 1'b0;
         press_consumed_ff <= 1'b0;
         press_start_ff    <= '0;
         last_activity_ff  <= '0;
      end else if (step) begin
         light_mode_ff     <= light_mode_in;
         key_prev_ff       <= key_prev_in;
         press_consumed_ff <= press_consumed_in;
         press_start_ff    <= press_start_in;
         last_activity_ff  <= last_activity_in;
      end
   end

   assign result.action        = act;
   assign result.in_light_mode = light_mode_in;

endmodule

>>> rtl/power_button_sleep_controller.sv
// Top level of the power button sleep controller: input register, step logic, result register.
//
// The controller takes one request word per clock and returns exactly one result word for
// each, presented from the result register. A request is caught in an input register; once
// the result register is empty or being read, the step logic (a few 48-bit subtractions and
// compares on the key and idle state) updates the state and writes the result register,
// which also frees the input register, so back-to-back words pass at one per cycle and a
// stalled result side holds both stages. A start request resynchronizes the key and time
// state and reports no action. The four timing registers are written on the csr channel,
// which is always ready; they should be changed only while no words are in flight.
module power_button_sleep_controller
   import pbsc_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   // Request channel.
   input  logic                       req_tvalid,
   output logic                       req_tready,
   // tdata: now_time[47:0], key_down[48], touch_seen[49], sleep_permitted[50], zero[55:51]
   input  logic [REQ_TDATA_WIDTH-1:0] req_tdata,
   // tuser: opcode[0]
   input  logic                       req_tuser,
   // Result channel.
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   // tdata: action[2:0], in_light_mode[3], zero[7:4]
   output logic [RSP_TDATA_WIDTH-1:0] rsp_tdata,
   // Configuration write channel.
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [1:0]                 csr_index,
   input  logic [CFG_WIDTH-1:0]       csr_data
);

   logic         in_valid_ff, in_valid_in;
   req_item_type in_item_ff;
   logic         out_valid_ff, out_valid_in;
   rsp_item_type out_item_ff;
   logic         advance;
   logic         req_take;
   cfg_type      cfg;
   rsp_item_type step_result;

   // Handshake between the two register stages.
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_take   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   assign in_valid_in  = req_take || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_tready);

   pbsc_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_valid && csr_ready),
      .wr_index (reg_index_type'(csr_index)),
      .wr_data  (csr_data),
      .cfg      (cfg)
   );

   pbsc_core u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .item   (in_item_ff),
      .cfg    (cfg),
      .result (step_result)
   );

   // Valid flags of both stages.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_item_ff.opcode          <= opcode_type'(req_tuser);
         in_item_ff.now_time        <= req_tdata[TIME_WIDTH-1:0];
         in_item_ff.key_down        <= req_tdata[TIME_WIDTH];
         in_item_ff.touch_seen      <= req_tdata[TIME_WIDTH+1];
         in_item_ff.sleep_permitted <= req_tdata[TIME_WIDTH+2];
      end
      if (advance) begin
         out_item_ff <= step_result;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {4'b0000, out_item_ff.in_light_mode, out_item_ff.action};

`ifndef SYNTH
   // Leaving light sleep always reports active mode.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && out_item_ff.action == ACT_EXIT_LIGHT |-> !out_item_ff.in_light_mode)
      else $error("exit light result reports light mode");

   // Entering light sleep always reports light mode.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && out_item_ff.action == ACT_ENTER_LIGHT |-> out_item_ff.in_light_mode)
      else $error("enter light result reports active mode");

   // Power off is only requested from active mode.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && out_item_ff.action == ACT_POWER_OFF |-> !out_item_ff.in_light_mode)
      else $error("power off requested in light mode");

   // A held input word is never dropped.
   assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(in_item_ff))
      else $error("input word lost while stalled");
`endif

endmodule
